>>> rtl/core/jlrf_pkg.sv
// Shared types and constants for the jerk-limited reference filter.
// Holds fixed-point widths, register indexes and lane control/config structs.
// Depends on nothing; every other file in rtl/core uses it.
`default_nettype none

package jlrf_pkg;

  localparam int DATA_W      = 32;
  localparam int CFG_W       = 31;
  localparam int FRAC_BITS   = 16;
  localparam int TICK_PERIOD = 655;
  localparam int LANES       = 4;
  localparam int LANE_YAW    = 3;
  localparam int REG_COUNT   = 8;
  localparam int IDX_W       = $clog2(REG_COUNT);

  // Full product of two data-wide operands, the shifted product term, and
  // room for a three-operand sum of such terms.
  localparam int PROD_W = 2 * DATA_W;
  localparam int TERM_W = PROD_W - FRAC_BITS;
  localparam int DIFF_W = TERM_W + 2;
  localparam int ERR_W  = DATA_W + 2;

  localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
  localparam logic [63:0] PI_ROUND =
    (PI_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
  localparam logic signed [ERR_W-1:0] PI_FX     = $signed(PI_ROUND[ERR_W-1:0]);
  localparam logic signed [ERR_W-1:0] TWO_PI_FX = PI_FX <<< 1;

  localparam logic signed [DATA_W-1:0] TICK_FX = DATA_W'(TICK_PERIOD);

  typedef enum logic [IDX_W-1:0] {
    REG_POS_GAIN         = 3'd0,
    REG_DAMP_GAIN        = 3'd1,
    REG_ACC_STEP_MAX     = 3'd2,
    REG_ACC_LIMIT        = 3'd3,
    REG_VEL_LIMIT        = 3'd4,
    REG_YAW_ACC_STEP_MAX = 3'd5,
    REG_YAW_ACC_LIMIT    = 3'd6,
    REG_YAW_RATE_LIMIT   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic start;
    logic init;
    logic wrap;
  } lane_ctl_t;

  typedef struct packed {
    logic [CFG_W-1:0] pos_gain;
    logic [CFG_W-1:0] damp_gain;
    logic [CFG_W-1:0] step_max;
    logic [CFG_W-1:0] acc_limit;
    logic [CFG_W-1:0] vel_limit;
  } lane_cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/jlrf_cmd_if.sv
// Command channel of the reference filter: opcode and the four targets.
// Uses widths from jlrf_pkg.
`default_nettype none

interface jlrf_cmd_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  opcode;
  logic signed [jlrf_pkg::DATA_W-1:0]    target_x;
  logic signed [jlrf_pkg::DATA_W-1:0]    target_y;
  logic signed [jlrf_pkg::DATA_W-1:0]    target_z;
  logic signed [jlrf_pkg::DATA_W-1:0]    target_yaw;

  modport source (output valid, opcode, target_x, target_y, target_z, target_yaw,
                  input ready);
  modport sink   (input valid, opcode, target_x, target_y, target_z, target_yaw,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/jlrf_rsp_if.sv
// Result channel of the reference filter: position, velocity, acceleration,
// heading and heading rate. Uses widths from jlrf_pkg.
`default_nettype none

interface jlrf_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [jlrf_pkg::DATA_W-1:0] ref_pos_x;
  logic signed [jlrf_pkg::DATA_W-1:0] ref_pos_y;
  logic signed [jlrf_pkg::DATA_W-1:0] ref_pos_z;
  logic signed [jlrf_pkg::DATA_W-1:0] ref_vel_x;
  logic signed [jlrf_pkg::DATA_W-1:0] ref_vel_y;
  logic signed [jlrf_pkg::DATA_W-1:0] ref_vel_z;
  logic signed [jlrf_pkg::DATA_W-1:0] ref_acc_x;
  logic signed [jlrf_pkg::DATA_W-1:0] ref_acc_y;
  logic signed [jlrf_pkg::DATA_W-1:0] ref_acc_z;
  logic signed [jlrf_pkg::DATA_W-1:0] ref_heading;
  logic signed [jlrf_pkg::DATA_W-1:0] ref_heading_rate;

  modport source (output valid, ref_pos_x, ref_pos_y, ref_pos_z, ref_vel_x, ref_vel_y,
                  ref_vel_z, ref_acc_x, ref_acc_y, ref_acc_z, ref_heading,
                  ref_heading_rate, input ready);
  modport sink   (input valid, ref_pos_x, ref_pos_y, ref_pos_z, ref_vel_x, ref_vel_y,
                  ref_vel_z, ref_acc_x, ref_acc_y, ref_acc_z, ref_heading,
                  ref_heading_rate, output ready);
endinterface

`default_nettype wire

>>> rtl/core/jlrf_axis.sv
// One filter lane: error, second-order law, jerk/acc/vel clamps and
// integration for a single axis, sequenced over one shared multiplier.
// Depends on jlrf_pkg.
`default_nettype none

module jlrf_axis (
  input  wire                              clk,
  input  wire                              rst,
  input  jlrf_pkg::lane_ctl_t              ctl,
  input  wire  signed [jlrf_pkg::DATA_W-1:0] target,
  input  jlrf_pkg::lane_cfg_t              cfg,
  output logic                             done,
  output logic signed [jlrf_pkg::DATA_W-1:0] pos,
  output logic signed [jlrf_pkg::DATA_W-1:0] vel,
  output logic signed [jlrf_pkg::DATA_W-1:0] acc
);
  import jlrf_pkg::*;

  typedef enum logic [10:0] {
    L_IDLE = 11'b000_0000_0001,
    L_ERR  = 11'b000_0000_0010,
    L_MP   = 11'b000_0000_0100,
    L_MD   = 11'b000_0000_1000,
    L_DIFF = 11'b000_0001_0000,
    L_JERK = 11'b000_0010_0000,
    L_ACC  = 11'b000_0100_0000,
    L_MA   = 11'b000_1000_0000,
    L_VEL  = 11'b001_0000_0000,
    L_MV   = 11'b010_0000_0000,
    L_POS  = 11'b100_0000_0000
  } lane_state_t;

  localparam logic signed [DATA_W-1:0] MAX_D = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] MIN_D = {1'b1, {(DATA_W-1){1'b0}}};

  function automatic logic signed [DIFF_W-1:0] ext_d(input logic signed [DATA_W-1:0] v);
    return {{(DIFF_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

  function automatic logic signed [DIFF_W-1:0] ext_t(input logic signed [TERM_W-1:0] v);
    return {{(DIFF_W-TERM_W){v[TERM_W-1]}}, v};
  endfunction

  // Symmetric clamp; a magnitude equal to the limit passes.
  function automatic logic signed [DIFF_W-1:0] clamp_lim(input logic signed [DIFF_W-1:0] v,
                                                         input logic [CFG_W-1:0] lim);
    logic signed [DIFF_W-1:0] lim_d;
    lim_d = $signed({{(DIFF_W-CFG_W){1'b0}}, lim});
    if (v > lim_d) return lim_d;
    else if (v < -lim_d) return -lim_d;
    else return v;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_d(input logic signed [DIFF_W-1:0] v);
    if (v > ext_d(MAX_D)) return MAX_D;
    else if (v < ext_d(MIN_D)) return MIN_D;
    else return v[DATA_W-1:0];
  endfunction

  lane_state_t state;

  logic signed [DATA_W-1:0] tgt;
  logic signed [DATA_W-1:0] err;
  logic signed [PROD_W-1:0] prod;
  logic signed [TERM_W-1:0] pterm;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] sum;

  logic signed [DATA_W-1:0] mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [TERM_W-1:0] term_now;
  logic signed [ERR_W-1:0]  e_raw;
  logic signed [ERR_W-1:0]  e_wrap;

  assign prod_sh  = prod >>> FRAC_BITS;
  assign term_now = $signed(prod_sh[TERM_W-1:0]);

  // Heading error is pulled back by two pi once when it lies beyond pi.
  always_comb begin
    e_raw = {{(ERR_W-DATA_W){tgt[DATA_W-1]}}, tgt} - {{(ERR_W-DATA_W){pos[DATA_W-1]}}, pos};
    if (ctl.wrap && (e_raw > PI_FX)) e_wrap = e_raw - TWO_PI_FX;
    else if (ctl.wrap && (e_raw < -PI_FX)) e_wrap = e_raw + TWO_PI_FX;
    else e_wrap = e_raw;
  end

  always_comb begin
    case (state)
      L_MP: begin
        mul_a = $signed({1'b0, cfg.pos_gain});
        mul_b = err;
      end
      L_MD: begin
        mul_a = $signed({1'b0, cfg.damp_gain});
        mul_b = vel;
      end
      L_MA: begin
        mul_a = acc;
        mul_b = TICK_FX;
      end
      L_MV: begin
        mul_a = vel;
        mul_b = TICK_FX;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      L_IDLE: tgt   <= target;
      L_ERR:  err   <= sat_d({{(DIFF_W-ERR_W){e_wrap[ERR_W-1]}}, e_wrap});
      L_MD:   pterm <= term_now;
      L_DIFF: diff  <= ext_t(pterm) - ext_t(term_now) - ext_d(acc);
      L_JERK: sum   <= ext_d(acc) + clamp_lim(diff, cfg.step_max);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
      pos   <= '0;
      vel   <= '0;
      acc   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        L_IDLE: begin
          if (ctl.start) begin
            if (ctl.init) begin
              pos  <= target;
              vel  <= '0;
              acc  <= '0;
              done <= 1'b1;
            end else begin
              state <= L_ERR;
            end
          end
        end
        L_ERR:  state <= L_MP;
        L_MP:   state <= L_MD;
        L_MD:   state <= L_DIFF;
        L_DIFF: state <= L_JERK;
        L_JERK: state <= L_ACC;
        L_ACC: begin
          acc   <= DATA_W'(clamp_lim(sum, cfg.acc_limit));
          state <= L_MA;
        end
        L_MA:   state <= L_VEL;
        L_VEL: begin
          vel   <= DATA_W'(clamp_lim(ext_d(vel) + ext_t(term_now), cfg.vel_limit));
          state <= L_MV;
        end
        L_MV:   state <= L_POS;
        L_POS: begin
          pos   <= sat_d(ext_d(pos) + ext_t(term_now));
          done  <= 1'b1;
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/jlrf_merge.sv
// Result stage: gathers the four lanes' state into one result word and
// holds it in an output register until the receiver takes it.
// Depends on jlrf_pkg and jlrf_rsp_if.
`default_nettype none

module jlrf_merge (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                load,
  input  wire  signed [jlrf_pkg::DATA_W-1:0] lane_pos [jlrf_pkg::LANES],
  input  wire  signed [jlrf_pkg::DATA_W-1:0] lane_vel [jlrf_pkg::LANES],
  input  wire  signed [jlrf_pkg::DATA_W-1:0] lane_acc [jlrf_pkg::LANES],
  output logic                               free,
  jlrf_rsp_if.source                         rsp
);
  import jlrf_pkg::*;

  assign free = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // The heading lane reports its position as heading and its velocity as rate.
  always_ff @(posedge clk) begin
    if (load) begin
      rsp.ref_pos_x        <= lane_pos[0];
      rsp.ref_pos_y        <= lane_pos[1];
      rsp.ref_pos_z        <= lane_pos[2];
      rsp.ref_vel_x        <= lane_vel[0];
      rsp.ref_vel_y        <= lane_vel[1];
      rsp.ref_vel_z        <= lane_vel[2];
      rsp.ref_acc_x        <= lane_acc[0];
      rsp.ref_acc_y        <= lane_acc[1];
      rsp.ref_acc_z        <= lane_acc[2];
      rsp.ref_heading      <= lane_pos[LANE_YAW];
      rsp.ref_heading_rate <= lane_vel[LANE_YAW];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/jerk_limited_reference_filter_core.sv
// Jerk-limited second-order reference filter, top level.
// Channels: cmd takes one word per tick (opcode, target x/y/z/yaw); rsp gives
// one word per accepted command (position, velocity, acceleration, heading,
// heading rate). Both use valid/ready; a word moves when both are high.
// Configuration: cfg_we writes cfg_data into register cfg_index; the user must
// write only while the block is idle, which the block itself does not enforce.
// A filter tick runs four lanes (x, y, z, heading) in lockstep, each stepping
// its own multiplier through ten states; once the last state is done the
// result word is loaded and cmd ready returns in that same cycle it is valid,
// if the output register is free. An init command loads its target directly
// with no steps. A new command is taken only after the last result is loaded.
// The per-lane multiplier, used four times per tick, sets the tick length.
// While the receiver stalls, the finished word waits in the output register;
// a further finished tick waits in the lanes, and cmd stays low until the
// output register frees.
// Reset (rst, synchronous) zeroes config registers and lane pos/vel/acc.
// Depends on jlrf_pkg, jlrf_cmd_if, jlrf_rsp_if, jlrf_axis, jlrf_merge.
`default_nettype none

module jerk_limited_reference_filter_core (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_we,
  input  wire  [jlrf_pkg::IDX_W-1:0]        cfg_index,
  input  wire  [jlrf_pkg::CFG_W-1:0]        cfg_data,
  jlrf_cmd_if.sink                          cmd,
  jlrf_rsp_if.source                        rsp
);
  import jlrf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_PUSH = 3'b100
  } top_state_t;

  top_state_t state;

  logic [CFG_W-1:0] cfg_regs [REG_COUNT];

  lane_cfg_t lin_cfg;
  lane_cfg_t yaw_cfg;

  logic signed [DATA_W-1:0] lane_tgt [LANES];
  logic signed [DATA_W-1:0] lane_pos [LANES];
  logic signed [DATA_W-1:0] lane_vel [LANES];
  logic signed [DATA_W-1:0] lane_acc [LANES];
  logic [LANES-1:0]         lane_done;

  logic accept;
  logic free;
  logic load;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) cfg_regs[i] <= '0;
    end else if (cfg_we) begin
      cfg_regs[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    lin_cfg.pos_gain  = cfg_regs[REG_POS_GAIN];
    lin_cfg.damp_gain = cfg_regs[REG_DAMP_GAIN];
    lin_cfg.step_max  = cfg_regs[REG_ACC_STEP_MAX];
    lin_cfg.acc_limit = cfg_regs[REG_ACC_LIMIT];
    lin_cfg.vel_limit = cfg_regs[REG_VEL_LIMIT];
    yaw_cfg.pos_gain  = cfg_regs[REG_POS_GAIN];
    yaw_cfg.damp_gain = cfg_regs[REG_DAMP_GAIN];
    yaw_cfg.step_max  = cfg_regs[REG_YAW_ACC_STEP_MAX];
    yaw_cfg.acc_limit = cfg_regs[REG_YAW_ACC_LIMIT];
    yaw_cfg.vel_limit = cfg_regs[REG_YAW_RATE_LIMIT];
  end

  assign cmd.ready = (state == ST_IDLE);
  assign accept    = cmd.valid && cmd.ready;

  assign lane_tgt[0] = cmd.target_x;
  assign lane_tgt[1] = cmd.target_y;
  assign lane_tgt[2] = cmd.target_z;
  assign lane_tgt[3] = cmd.target_yaw;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    lane_ctl_t ctl;
    assign ctl.start = accept;
    assign ctl.init  = cmd.opcode;
    assign ctl.wrap  = (i == LANE_YAW);

    jlrf_axis u_axis (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .target (lane_tgt[i]),
      .cfg    ((i == LANE_YAW) ? yaw_cfg : lin_cfg),
      .done   (lane_done[i]),
      .pos    (lane_pos[i]),
      .vel    (lane_vel[i]),
      .acc    (lane_acc[i])
    );
  end

  // Lanes run in lockstep, so they finish together; the lane state is held
  // until the word has been copied into the output register.
  assign load = free && (((state == ST_RUN) && (&lane_done)) || (state == ST_PUSH));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: if (accept) state <= ST_RUN;
        ST_RUN: begin
          if (&lane_done) state <= free ? ST_IDLE : ST_PUSH;
        end
        ST_PUSH: if (free) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  jlrf_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .lane_pos (lane_pos),
    .lane_vel (lane_vel),
    .lane_acc (lane_acc),
    .free     (free),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for jerk_limited_reference_filter_core: a queue-fed command driver,
// a result monitor and a bit-exact fixed-point predictor of the filter state.
// Depends on jlrf_pkg, jlrf_cmd_if, jlrf_rsp_if and the core RTL.

module tb;
  import jlrf_pkg::*;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_INIT = 1'b1;

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;
  localparam longint CFG_MAX  = 64'sd2147483647;
  localparam longint UNIT     = 64'sd1 << FRAC_BITS;

  localparam logic [63:0] PI_Q60_BITS = 64'h3243F6A8885A308D;
  localparam longint HALF_TURN =
    longint'((PI_Q60_BITS + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS));

  localparam int REF_FIELDS   = 11;
  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int REPORT_MAX   = 10;
  localparam int IDLE_PCT     = 19;

  typedef struct packed {
    logic                     opcode;
    logic signed [DATA_W-1:0] tx;
    logic signed [DATA_W-1:0] ty;
    logic signed [DATA_W-1:0] tz;
    logic signed [DATA_W-1:0] tyaw;
  } cmd_word_t;

  // Element 0 is ref_pos_x, element 10 is ref_heading_rate.
  typedef logic [REF_FIELDS-1:0][DATA_W-1:0] ref_word_t;

  string field_name [REF_FIELDS] = '{"ref_pos_x", "ref_pos_y", "ref_pos_z",
                                     "ref_vel_x", "ref_vel_y", "ref_vel_z",
                                     "ref_acc_x", "ref_acc_y", "ref_acc_z",
                                     "ref_heading", "ref_heading_rate"};

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]   cfg_data;

  jlrf_cmd_if cmd_ch ();
  jlrf_rsp_if rsp_ch ();

  jerk_limited_reference_filter_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch),
    .rsp       (rsp_ch)
  );

  cmd_word_t cmd_backlog [$];
  ref_word_t predicted_refs [$];
  cmd_word_t cur_cmd;

  longint cfg_shadow [REG_COUNT];
  longint cfg_next [REG_COUNT];
  int     pos_q [3];
  int     vel_q [3];
  int     acc_q [3];
  int     hd_q;
  int     hd_rate_q;
  int     hd_acc_q;

  int pushed_total;
  int results_seen;
  int mismatch_count;
  int quiet_cycles;
  int src_idle_pct;
  int snk_idle_pct;
  int hold_cnt;
  bit hold_arm;
  bit hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint fx_scale(input longint gain, input longint x);
    return (gain * x) >>> FRAC_BITS;
  endfunction

  function automatic longint clamp_mag(input longint x, input longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  function automatic longint sat_word(input longint x);
    if (x > WORD_MAX) return WORD_MAX;
    if (x < WORD_MIN) return WORD_MIN;
    return x;
  endfunction

  function automatic void axis_advance(input longint err, inout int p, inout int v,
                                       inout int a, input longint step_max,
                                       input longint acc_lim, input longint vel_lim);
    longint want;
    longint delta;
    longint na;
    longint nv;
    want  = fx_scale(cfg_shadow[REG_POS_GAIN], err) -
            fx_scale(cfg_shadow[REG_DAMP_GAIN], longint'(v));
    delta = clamp_mag(want - longint'(a), step_max);
    na    = clamp_mag(longint'(a) + delta, acc_lim);
    nv    = clamp_mag(longint'(v) + fx_scale(na, TICK_PERIOD), vel_lim);
    a = int'(na);
    v = int'(nv);
    p = int'(sat_word(longint'(p) + fx_scale(nv, TICK_PERIOD)));
  endfunction

  task automatic step_reference(input cmd_word_t c);
    ref_word_t w;
    longint    err;
    longint    tgt [3];
    tgt[0] = longint'(c.tx);
    tgt[1] = longint'(c.ty);
    tgt[2] = longint'(c.tz);
    if (c.opcode == OP_INIT) begin
      for (int i = 0; i < 3; i++) begin
        pos_q[i] = int'(tgt[i]);
        vel_q[i] = 0;
        acc_q[i] = 0;
      end
      hd_q      = c.tyaw;
      hd_rate_q = 0;
      hd_acc_q  = 0;
    end else begin
      for (int i = 0; i < 3; i++) begin
        err = sat_word(tgt[i] - longint'(pos_q[i]));
        axis_advance(err, pos_q[i], vel_q[i], acc_q[i], cfg_shadow[REG_ACC_STEP_MAX],
                     cfg_shadow[REG_ACC_LIMIT], cfg_shadow[REG_VEL_LIMIT]);
      end
      // The yaw error is folded by one full turn at most, then saturated.
      err = longint'(c.tyaw) - longint'(hd_q);
      if (err > HALF_TURN) err = err - 2 * HALF_TURN;
      else if (err < -HALF_TURN) err = err + 2 * HALF_TURN;
      err = sat_word(err);
      axis_advance(err, hd_q, hd_rate_q, hd_acc_q, cfg_shadow[REG_YAW_ACC_STEP_MAX],
                   cfg_shadow[REG_YAW_ACC_LIMIT], cfg_shadow[REG_YAW_RATE_LIMIT]);
    end
    for (int i = 0; i < 3; i++) begin
      w[i]     = pos_q[i];
      w[3 + i] = vel_q[i];
      w[6 + i] = acc_q[i];
    end
    w[9]  = hd_q;
    w[10] = hd_rate_q;
    predicted_refs.push_back(w);
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        step_reference(cur_cmd);
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          cur_cmd = cmd_backlog.pop_front();
          cmd_ch.valid      <= 1'b1;
          cmd_ch.opcode     <= cur_cmd.opcode;
          cmd_ch.target_x   <= cur_cmd.tx;
          cmd_ch.target_y   <= cur_cmd.ty;
          cmd_ch.target_z   <= cur_cmd.tz;
          cmd_ch.target_yaw <= cur_cmd.tyaw;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_ref_word();
    ref_word_t got;
    ref_word_t want;
    got = {rsp_ch.ref_heading_rate, rsp_ch.ref_heading,
           rsp_ch.ref_acc_z, rsp_ch.ref_acc_y, rsp_ch.ref_acc_x,
           rsp_ch.ref_vel_z, rsp_ch.ref_vel_y, rsp_ch.ref_vel_x,
           rsp_ch.ref_pos_z, rsp_ch.ref_pos_y, rsp_ch.ref_pos_x};
    results_seen++;
    if (predicted_refs.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
        $display("result word %0d arrived with nothing predicted", results_seen);
    end else begin
      want = predicted_refs.pop_front();
      for (int i = 0; i < REF_FIELDS; i++) begin
        if (got[i] !== want[i]) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("result word %0d %s: expected %0d actual %0d", results_seen,
                     field_name[i], $signed(want[i]), $signed(got[i]));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        check_ref_word();
      end
      rsp_ch.ready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // The receiver holds off once for a long stretch so the core fills and stalls cmd.
  always @(posedge clk) begin
    if (rst) begin
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_arm && !hold_done) begin
      hold_cnt  <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL jerk_limited_reference_filter_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic push_cmd(input logic op, input longint x, input longint y,
                          input longint z, input longint yaw);
    cmd_word_t c;
    c.opcode = op;
    c.tx     = DATA_W'(x);
    c.ty     = DATA_W'(y);
    c.tz     = DATA_W'(z);
    c.tyaw   = DATA_W'(yaw);
    cmd_backlog.push_back(c);
    pushed_total++;
  endtask

  task automatic write_reg(input reg_idx_t idx, input longint val);
    @(posedge clk);
    cfg_we     <= 1'b1;
    cfg_index  <= idx;
    cfg_data   <= val[CFG_W-1:0];
    cfg_shadow[idx] = val & CFG_MAX;
  endtask

  task automatic load_config();
    reg_idx_t r;
    r = r.first();
    repeat (REG_COUNT) begin
      write_reg(r, cfg_next[r]);
      r = r.next();
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (results_seen < pushed_total) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic longint typical_value(input reg_idx_t r);
    case (r)
      REG_POS_GAIN:         return $urandom_range(UNIT / 4, 16 * UNIT);
      REG_DAMP_GAIN:        return $urandom_range(UNIT / 4, 8 * UNIT);
      REG_ACC_STEP_MAX,
      REG_YAW_ACC_STEP_MAX: return $urandom_range(UNIT / 1024, 2 * UNIT);
      default:              return $urandom_range(UNIT / 64, 8 * UNIT);
    endcase
  endfunction

  // Kind 0 keeps values near a flying vehicle's range, kind 1 spreads them over all
  // 31 bits, kind 2 mixes zero, one and full scale with ordinary values.
  task automatic pick_config(input int kind);
    reg_idx_t r;
    r = r.first();
    repeat (REG_COUNT) begin
      case (kind)
        0: cfg_next[r] = typical_value(r);
        1: cfg_next[r] = longint'($urandom) & CFG_MAX;
        default: begin
          case ($urandom_range(0, 3))
            0:       cfg_next[r] = 0;
            1:       cfg_next[r] = CFG_MAX;
            2:       cfg_next[r] = 1;
            default: cfg_next[r] = typical_value(r);
          endcase
        end
      endcase
      r = r.next();
    end
  endtask

  function automatic logic signed [DATA_W-1:0] near_pos();
    return DATA_W'(longint'($urandom_range(0, 40 * UNIT)) - 20 * UNIT);
  endfunction

  function automatic logic signed [DATA_W-1:0] near_angle();
    return DATA_W'(longint'($urandom_range(0, 8 * HALF_TURN)) - 4 * HALF_TURN);
  endfunction

  function automatic logic signed [DATA_W-1:0] offset_from(
      input logic signed [DATA_W-1:0] base, input longint span);
    return base + DATA_W'(longint'($urandom_range(0, 2 * span)) - span);
  endfunction

  // An init followed by a run of ticks chasing a goal that moves now and then.
  task automatic add_track();
    logic signed [DATA_W-1:0] sx, sy, sz, syaw;
    logic signed [DATA_W-1:0] gx, gy, gz, gyaw;
    longint span;
    int     len;
    bit     moved;
    if ($urandom_range(0, 7) == 0) begin
      sx = $urandom; sy = $urandom; sz = $urandom; syaw = $urandom;
    end else begin
      sx = near_pos(); sy = near_pos(); sz = near_pos(); syaw = near_angle();
    end
    push_cmd(OP_INIT, sx, sy, sz, syaw);
    len = $urandom_range(5, 30);
    moved = 1'b0;
    repeat (len) begin
      if (!moved || $urandom_range(0, 9) == 0) begin
        span = ($urandom_range(0, 3) == 0) ? 1000 : 10 * UNIT;
        gx   = offset_from(sx, span);
        gy   = offset_from(sy, span);
        gz   = offset_from(sz, span);
        gyaw = offset_from(syaw, 2 * HALF_TURN);
        moved = 1'b1;
      end
      push_cmd(OP_TICK, gx, gy, gz, gyaw);
      len = len - 1;
    end
  endtask

  task automatic add_random(input int n);
    int stop_at;
    stop_at = pushed_total + n;
    while (pushed_total < stop_at) begin
      case ($urandom_range(0, 99) / 25)
        0, 1, 2: add_track();
        default: begin
          if ($urandom_range(0, 1) == 0) begin
            push_cmd(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom);
          end else begin
            repeat ($urandom_range(1, 4))
              push_cmd(OP_TICK, $urandom, $urandom, $urandom, $urandom);
          end
        end
      endcase
    end
  endtask

  initial begin
    int base;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    cmd_ch.valid      = 1'b0;
    cmd_ch.opcode     = OP_TICK;
    cmd_ch.target_x   = '0;
    cmd_ch.target_y   = '0;
    cmd_ch.target_z   = '0;
    cmd_ch.target_yaw = '0;
    rsp_ch.ready      = 1'b0;
    src_idle_pct      = IDLE_PCT;
    snk_idle_pct      = IDLE_PCT;
    hold_arm          = 1'b0;
    pushed_total      = 0;
    results_seen      = 0;
    mismatch_count    = 0;
    quiet_cycles      = 0;
    for (int i = 0; i < REG_COUNT; i++) cfg_shadow[i] = 0;
    for (int i = 0; i < 3; i++) begin
      pos_q[i] = 0;
      vel_q[i] = 0;
      acc_q[i] = 0;
    end
    hd_q      = 0;
    hd_rate_q = 0;
    hd_acc_q  = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: every limit is zero, so ticks must not move anything.
    push_cmd(OP_INIT, WORD_MIN, WORD_MAX, 0, WORD_MAX);
    push_cmd(OP_TICK, WORD_MAX, WORD_MIN, 5 * UNIT, WORD_MIN);
    wait_drained();

    cfg_next[REG_POS_GAIN]         = 4 * UNIT;
    cfg_next[REG_DAMP_GAIN]        = (28 * UNIT) / 10;
    cfg_next[REG_ACC_STEP_MAX]     = UNIT / 2;
    cfg_next[REG_ACC_LIMIT]        = 3 * UNIT;
    cfg_next[REG_VEL_LIMIT]        = 2 * UNIT;
    cfg_next[REG_YAW_ACC_STEP_MAX] = (3 * UNIT) / 10;
    cfg_next[REG_YAW_ACC_LIMIT]    = 2 * UNIT;
    cfg_next[REG_YAW_RATE_LIMIT]   = UNIT;
    load_config();
    // Yaw error of exactly pi stays, just beyond it folds, both signs.
    push_cmd(OP_INIT, 0, 0, 0, 0);
    push_cmd(OP_TICK, 5 * UNIT, -5 * UNIT, UNIT, HALF_TURN);
    push_cmd(OP_TICK, 5 * UNIT, -5 * UNIT, UNIT, HALF_TURN);
    push_cmd(OP_INIT, 0, 0, 0, 0);
    push_cmd(OP_TICK, 0, 0, 0, HALF_TURN + 1);
    push_cmd(OP_INIT, 0, 0, 0, 0);
    push_cmd(OP_TICK, 0, 0, 0, -HALF_TURN - 1);
    push_cmd(OP_TICK, 0, 0, 0, -HALF_TURN);
    // Yaw error that stays out of range after folding saturates.
    push_cmd(OP_INIT, 0, 0, 0, WORD_MAX);
    push_cmd(OP_TICK, 0, 0, 0, WORD_MIN);
    // Position error from one end of the range to the other saturates.
    push_cmd(OP_INIT, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
    repeat (3) push_cmd(OP_TICK, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
    push_cmd(OP_INIT, WORD_MAX, WORD_MAX, WORD_MAX, 0);
    push_cmd(OP_TICK, WORD_MAX, WORD_MAX, WORD_MAX, 0);
    wait_drained();

    // Full-scale gains and limits drive every sum into saturation.
    for (int i = 0; i < REG_COUNT; i++) cfg_next[i] = CFG_MAX;
    load_config();
    push_cmd(OP_INIT, 0, 0, 0, 0);
    push_cmd(OP_TICK, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MAX);
    push_cmd(OP_TICK, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MAX);
    push_cmd(OP_TICK, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MIN);
    push_cmd(OP_INIT, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN);
    push_cmd(OP_TICK, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX);
    wait_drained();

    for (int p = 0; p < 7; p++) begin
      pick_config(p % 3);
      load_config();
      src_idle_pct = (p == 3) ? 0 : IDLE_PCT;
      snk_idle_pct = (p == 3) ? 0 : IDLE_PCT;
      base = results_seen;
      add_random(115);
      if (p == 3) begin
        while (results_seen < base + 20) @(posedge clk);
        hold_arm = 1'b1;
      end
      wait_drained();
    end

    if (mismatch_count == 0 && predicted_refs.size() == 0) begin
      $display("PASS jerk_limited_reference_filter_core");
    end else begin
      $display("FAIL jerk_limited_reference_filter_core");
    end
    $finish;
  end

endmodule

>>> jerk_limited_reference_filter_core.f
rtl/core/jlrf_pkg.sv
rtl/core/jlrf_cmd_if.sv
rtl/core/jlrf_rsp_if.sv
rtl/core/jlrf_axis.sv
rtl/core/jlrf_merge.sv
rtl/core/jerk_limited_reference_filter_core.sv
dv/tb.sv
